>>> hw/rtl/calendar_minute_converter_core_assert.svh
// Assertion macros for the calendar minute converter
`ifndef CALENDAR_MINUTE_CONVERTER_CORE_ASSERT_SVH
`define CALENDAR_MINUTE_CONVERTER_CORE_ASSERT_SVH
`define CMC_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CMC_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/cmc_pkg.sv
// Shared constants, types and functions of the calendar minute converter
package cmc_pkg;
  localparam int Stages = 4;
  localparam logic [31:0] MinDay = 32'd1440;
  localparam logic [31:0] MinYear = 32'd525600;
  localparam logic OpToCount = 1'b0;
  localparam logic OpToDate = 1'b1;
  // reciprocals: x / d == (x * R) >> k over the operand ranges used
  localparam logic [27:0] DayRecip = 28'd190887436;   // 45, k = 33
  localparam logic [21:0] FourRecip = 22'd2939745;    // 1461, k = 32
  localparam logic [22:0] WeekRecip = 23'd4793491;    // 7, k = 25
  localparam logic [16:0] SecRecip = 17'd67109;       // 1000, k = 26
  localparam logic [10:0] HourRecip = 11'd1093;       // 60, k = 16

  typedef struct packed {
    logic        opcode;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [31:0] minute_count;
    logic [15:0] ms_in_minute;
  } req_t;

  typedef struct packed {
    logic [31:0] out_minute_count;
    logic [15:0] out_ms_in_minute;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [6:0]  out_second;
    logic [9:0]  out_millisecond;
    logic [2:0]  weekday;
  } res_t;

  // minutes in the months before the given month index 0..12
  function automatic logic [19:0] month_start(input logic [3:0] m, input logic leap);
    logic [19:0] v;
    case (m)
      4'd0: v = 20'd0;
      4'd1: v = 20'd44640;
      4'd2: v = 20'd84960;
      4'd3: v = 20'd129600;
      4'd4: v = 20'd172800;
      4'd5: v = 20'd217440;
      4'd6: v = 20'd260640;
      4'd7: v = 20'd305280;
      4'd8: v = 20'd349920;
      4'd9: v = 20'd393120;
      4'd10: v = 20'd437760;
      4'd11: v = 20'd480960;
      default: v = 20'd525600;
    endcase
    if (leap && m >= 4'd2) v = v + 20'd1440;
    return v;
  endfunction

  // days in the months before the given month index 0..12
  function automatic logic [8:0] month_first_day(input logic [3:0] m, input logic leap);
    logic [8:0] v;
    case (m)
      4'd0: v = 9'd0;
      4'd1: v = 9'd31;
      4'd2: v = 9'd59;
      4'd3: v = 9'd90;
      4'd4: v = 9'd120;
      4'd5: v = 9'd151;
      4'd6: v = 9'd181;
      4'd7: v = 9'd212;
      4'd8: v = 9'd243;
      4'd9: v = 9'd273;
      4'd10: v = 9'd304;
      4'd11: v = 9'd334;
      default: v = 9'd365;
    endcase
    if (leap && m >= 4'd2) v = v + 9'd1;
    return v;
  endfunction
endpackage

>>> hw/rtl/cmc_datapath.sv
// Four-stage conversion datapath with a shared enable
module cmc_datapath import cmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  req_t req,
  output logic out_valid,
  output res_t res
);
  logic [Stages-1:0] vld;
  req_t r1;
  // date to count partials
  logic [31:0] yrs1, mon1, rest1, sum2, cnt3;
  logic [15:0] ms1, ms2, ms3;
  logic        op2, op3;
  // count to date partials
  logic [21:0] days1;
  logic [6:0]  sec1, sec2, sec3;
  logic [15:0] msm2;
  logic [10:0] mod2, mod3;
  logic [21:0] sday2, wx2;
  logic [11:0] cyc2;
  logic [19:0] wq2;
  logic [13:0] year3;
  logic [8:0]  yd3;
  logic [4:0]  hour3;
  logic [2:0]  wd3;
  logic [9:0]  msec3;
  res_t        res_next;

  logic [15:0] yc;
  logic [13:0] n;
  logic [13:0] lp;
  logic [54:0] dprod;
  logic [32:0] sprod;
  logic [31:0] modx;
  logic [21:0] sday;
  logic [21:0] wx;
  logic [43:0] cprod;
  logic [44:0] wprod;
  logic [21:0] yr_rem;
  logic [1:0]  y3;
  logic [21:0] ydx;
  logic [15:0] yfull;
  logic [21:0] hprod;
  logic [21:0] r7x;
  logic [2:0]  r7;
  logic [15:0] msx;
  logic        lpy;
  logic [3:0]  mi;
  logic [8:0]  dd;
  logic [10:0] mn;

  always_comb begin
    yc = (req.year > 16'd11000) ? 16'd11000 : req.year;
    n = (yc > 16'd1970) ? yc[13:0] - 14'd1970 : 14'd0;
    lp = (yc > 16'd1970) ? ((yc[13:0] - 14'd1) >> 2) - 14'd492 : 14'd0;
    dprod = 55'(req.minute_count[31:5]) * 55'(DayRecip);
    sprod = 33'(req.ms_in_minute) * 33'(SecRecip);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Stages-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= req;
      yrs1 <= 32'(n) * MinYear + 32'(lp) * MinDay;
      mon1 <= 32'(month_start(req.month == 4'd0 ? 4'd0 : req.month - 4'd1,
                              req.year[1:0] == 2'b00));
      rest1 <= 32'(req.hour) * 32'd60 + 32'(req.minute)
             + 32'(req.day) * MinDay - MinDay;
      ms1 <= 16'(32'(req.second) * 32'd1000 + 32'(req.millisecond));
      days1 <= dprod[54:33];
      sec1 <= sprod[32:26];
    end
  end

  always_comb begin
    modx = r1.minute_count - 32'(days1) * MinDay;
    sday = days1 + 22'd365;
    cprod = 44'(sday) * 44'(FourRecip);
    wx = days1 + 22'd1;
    wprod = 45'(wx) * 45'(WeekRecip);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= r1.opcode;
      sum2 <= yrs1 + mon1 + rest1;
      ms2 <= ms1;
      sec2 <= sec1;
      msm2 <= r1.ms_in_minute;
      mod2 <= modx[10:0];
      sday2 <= sday;
      cyc2 <= cprod[43:32];
      wx2 <= wx;
      wq2 <= wprod[44:25];
    end
  end

  always_comb begin
    yr_rem = sday2 - 22'(cyc2) * 22'd1461;
    y3 = (yr_rem >= 22'd1095) ? 2'd3 : (yr_rem >= 22'd730) ? 2'd2 :
         (yr_rem >= 22'd365) ? 2'd1 : 2'd0;
    ydx = yr_rem - 22'(y3) * 22'd365;
    yfull = 16'd1969 + {2'b00, cyc2, 2'b00} + 16'(y3);
    hprod = 22'(mod2) * 22'(HourRecip);
    r7x = wx2 - 22'(wq2) * 22'd7;
    r7 = r7x[2:0];
    msx = msm2 - 16'(sec2) * 16'd1000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3 <= op2;
      cnt3 <= sum2;
      ms3 <= ms2;
      sec3 <= sec2;
      msec3 <= msx[9:0];
      year3 <= yfull[13:0];
      yd3 <= ydx[8:0];
      mod3 <= mod2;
      hour3 <= hprod[20:16];
      wd3 <= (r7 <= 3'd4) ? r7 + 3'd3 : r7 - 3'd4;
    end
  end

  always_comb begin
    lpy = year3[1:0] == 2'b00;
    mi = 4'd11;
    for (int k = 11; k >= 1; k--) begin
      if (yd3 < month_first_day(4'(k), lpy)) mi = 4'(k - 1);
    end
    dd = yd3 - month_first_day(mi, lpy) + 9'd1;
    mn = mod3 - 11'(hour3) * 11'd60;
    res_next = '0;
    if (op3 == OpToCount) begin
      res_next.out_minute_count = cnt3;
      res_next.out_ms_in_minute = ms3;
    end else begin
      res_next.out_year = year3;
      res_next.out_month = mi + 4'd1;
      res_next.out_day = dd[4:0];
      res_next.out_hour = hour3;
      res_next.out_minute = mn[5:0];
      res_next.out_second = sec3;
      res_next.out_millisecond = msec3;
      res_next.weekday = wd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

  assign out_valid = vld[Stages-1];

  `include "calendar_minute_converter_core_assert.svh"
  `CMC_ASSERT_NEXT(a_hold, !en, $stable(vld))
  `CMC_ASSERT_NEXT(a_adv, en && in_valid, vld[0])
  `CMC_ASSERT_IMP(a_wd, out_valid && res.weekday != 3'd0, res.out_minute_count == 32'd0)
endmodule

>>> hw/rtl/calendar_minute_converter_core.sv
// Calendar minute converter: date fields to epoch minutes and back.
// One request enters per cycle while the pipeline advances; each passes through the
// four datapath register stages, the last of which drives the output. The pipeline
// advances whenever the output slot is empty or is being taken, and holds as a whole
// otherwise.
module calendar_minute_converter_core import cmc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode, year, month, day, hour, minute, second, millisecond,
  // minute_count, ms_in_minute (low to high), zero padded
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_minute_count, out_ms_in_minute, out_year, out_month, out_day,
  // out_hour, out_minute, out_second, out_millisecond, weekday (low to high)
  output logic [103:0] m_tdata
);
  req_t req;
  res_t res;
  logic en, pv;

  assign req.opcode = s_tdata[0];
  assign req.year = s_tdata[16:1];
  assign req.month = s_tdata[20:17];
  assign req.day = s_tdata[25:21];
  assign req.hour = s_tdata[30:26];
  assign req.minute = s_tdata[36:31];
  assign req.second = s_tdata[42:37];
  assign req.millisecond = s_tdata[52:43];
  assign req.minute_count = s_tdata[84:53];
  assign req.ms_in_minute = s_tdata[100:85];

  assign en = !pv || m_tready;
  assign s_tready = en;
  assign m_tvalid = pv;

  cmc_datapath u_dp (.clk, .rst, .en, .in_valid(s_tvalid), .req,
                     .out_valid(pv), .res);

  assign m_tdata = {2'b00, res.weekday, res.out_millisecond, res.out_second,
                    res.out_minute, res.out_hour, res.out_day, res.out_month,
                    res.out_year, res.out_ms_in_minute, res.out_minute_count};
endmodule

>>> bench/calendar_minute_converter_core_test.sv
// Self-checking bench for the calendar minute converter: random and directed conversions
`timescale 1ns / 100ps

class conversion_board;
  logic [103:0] pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function logic [31:0] month_len(int idx, bit leap);
    if (idx == 1) return leap ? 32'd41760 : 32'd40320;
    case (idx)
      3, 5, 8, 10: return 32'd43200;
      default: return 32'd44640;
    endcase
  endfunction

  static function logic [103:0] convert(logic [103:0] req);
    logic [103:0] r;
    logic [63:0] acc;
    logic [31:0] yr, mo, cnt, remv, y, wd;
    logic [63:0] shifted, cycles;
    logic [15:0] msm;
    bit leap;
    int m;
    r = '0;
    if (req[0] == 1'b0) begin
      yr = req[16:1];
      mo = req[20:17];
      leap = (yr[1:0] == 2'b00);
      acc = 0;
      if (yr > 11000) yr = 11000;
      if (yr > 1970) acc = 64'(yr - 1970) * 525600 + 64'((yr - 1) / 4 - 492) * 1440;
      for (m = 1; m < mo && m <= 12; m++) acc += month_len(m - 1, leap);
      acc += 64'(req[30:26]) * 60 + req[36:31];
      acc += 64'(req[25:21]) * 1440;
      acc -= 1440;
      r[31:0] = acc[31:0];
      r[47:32] = 16'(32'(req[42:37]) * 1000 + req[52:43]);
    end else begin
      cnt = req[84:53];
      msm = req[100:85];
      shifted = 64'(cnt) + 525600;
      cycles = shifted / 2103840;
      remv = 32'(shifted % 2103840);
      y = remv / 525600;
      if (y > 3) y = 3;
      remv -= y * 525600;
      yr = 1969 + 32'(cycles * 4) + y;
      leap = (yr[1:0] == 2'b00);
      for (m = 0; m < 11; m++) begin
        if (remv < month_len(m, leap)) break;
        remv -= month_len(m, leap);
      end
      wd = (cnt / 1440 + 1) % 7 + 3;
      if (wd > 7) wd -= 7;
      r[61:48] = yr[13:0];
      r[65:62] = 4'(m + 1);
      r[70:66] = 5'(remv / 1440 + 1);
      remv = remv % 1440;
      r[75:71] = 5'(remv / 60);
      r[81:76] = 6'(remv % 60);
      r[88:82] = 7'(msm / 1000);
      r[98:89] = 10'(msm % 1000);
      r[101:99] = wd[2:0];
    end
    return r;
  endfunction

  function void note_request(logic [103:0] req);
    pending.push_back(convert(req));
  endfunction

  function void check_result(logic [103:0] got);
    logic [103:0] exp;
    if (pending.size() == 0) begin
      $error("unexpected result %h", got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (exp[31:0] !== got[31:0])
      $error("out_minute_count exp %0d got %0d", exp[31:0], got[31:0]);
    if (exp[47:32] !== got[47:32])
      $error("out_ms_in_minute exp %0d got %0d", exp[47:32], got[47:32]);
    if (exp[61:48] !== got[61:48])
      $error("out_year exp %0d got %0d", exp[61:48], got[61:48]);
    if (exp[65:62] !== got[65:62])
      $error("out_month exp %0d got %0d", exp[65:62], got[65:62]);
    if (exp[70:66] !== got[70:66])
      $error("out_day exp %0d got %0d", exp[70:66], got[70:66]);
    if (exp[75:71] !== got[75:71])
      $error("out_hour exp %0d got %0d", exp[75:71], got[75:71]);
    if (exp[81:76] !== got[81:76])
      $error("out_minute exp %0d got %0d", exp[81:76], got[81:76]);
    if (exp[88:82] !== got[88:82])
      $error("out_second exp %0d got %0d", exp[88:82], got[88:82]);
    if (exp[98:89] !== got[98:89])
      $error("out_millisecond exp %0d got %0d", exp[98:89], got[98:89]);
    if (exp[101:99] !== got[101:99])
      $error("weekday exp %0d got %0d", exp[101:99], got[101:99]);
    if (exp !== got) errors++;
  endfunction
endclass

module calendar_minute_converter_core_test;
  import cmc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [103:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  int send_idle = 0;
  int recv_idle = 0;
  conversion_board board = new();

  calendar_minute_converter_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [103:0] pack_date(logic [15:0] yr, logic [3:0] mo, logic [4:0] dy,
      logic [4:0] hr, logic [5:0] mi, logic [5:0] se, logic [9:0] ms);
    logic [103:0] d;
    d = '0;
    d[0] = OpToCount;
    d[16:1] = yr;
    d[20:17] = mo;
    d[25:21] = dy;
    d[30:26] = hr;
    d[36:31] = mi;
    d[42:37] = se;
    d[52:43] = ms;
    d[84:53] = $urandom;
    d[100:85] = 16'($urandom);
    return d;
  endfunction

  function automatic logic [103:0] pack_count(logic [31:0] cnt, logic [15:0] msm);
    logic [103:0] d;
    d = '0;
    d[52:0] = 53'({$urandom, $urandom});
    d[0] = OpToDate;
    d[84:53] = cnt;
    d[100:85] = msm;
    return d;
  endfunction

  task automatic send_request(logic [103:0] req);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(req);
  endtask

  task automatic send_random(int n);
    logic [103:0] d;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: d = pack_date(16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
            6'($urandom), 6'($urandom), 10'($urandom));
        1, 2: d = pack_count($urandom, 16'($urandom));
        3, 4: d = pack_count($urandom_range(32'd9000000), 16'($urandom_range(59999)));
        5: d = pack_date(16'($urandom_range(1960, 12000)), 4'($urandom_range(1, 12)),
            5'($urandom_range(1, 31)), 5'($urandom_range(23)), 6'($urandom_range(59)),
            6'($urandom_range(59)), 10'($urandom_range(999)));
        default: d = pack_date(16'($urandom_range(1970, 2200)), 4'($urandom_range(1, 12)),
            5'($urandom_range(1, 28)), 5'($urandom_range(23)), 6'($urandom_range(59)),
            6'($urandom_range(59)), 10'($urandom_range(999)));
      endcase
      send_request(d);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(pack_date(16'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0));
    send_request(pack_date(16'd1969, 4'd3, 5'd2, 5'd1, 6'd1, 6'd1, 10'd1));
    send_request(pack_date(16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0));
    send_request(pack_date(16'd2024, 4'd3, 5'd1, 5'd23, 6'd59, 6'd59, 10'd999));
    send_request(pack_date(16'd2023, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999));
    send_request(pack_date(16'd11000, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999));
    send_request(pack_date(16'd11001, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0));
    send_request(pack_date(16'hFFFF, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 10'd1023));
    send_request(pack_date(16'd2100, 4'd13, 5'd0, 5'd24, 6'd60, 6'd60, 10'd1000));
    send_request(pack_date(16'd2000, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30, 10'd500));
    send_request(pack_count(32'd0, 16'd0));
    send_request(pack_count(32'hFFFFFFFF, 16'hFFFF));
    send_request(pack_count(32'd1439, 16'd59999));
    send_request(pack_count(32'd1440, 16'd60000));
    send_request(pack_count(32'd525600, 16'd1000));
    send_request(pack_count(32'd1575360, 16'd999));
    send_request(pack_count(32'd1627200, 16'd12345));
    send_request(pack_count(32'd2103839, 16'd0));
    send_request(pack_count(32'h80000000, 16'h8000));
    drain();
    send_idle = 7;
    recv_idle = 61;
    send_random(300);
    drain();
    send_idle = 61;
    recv_idle = 7;
    send_random(300);
    send_idle = 0;
    recv_idle = 0;
    send_random(300);
    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cmc_pkg.sv
hw/rtl/cmc_datapath.sv
hw/rtl/calendar_minute_converter_core.sv
bench/calendar_minute_converter_core_test.sv
